FILE: rtl/core/sxy_pkg.sv
// sxy_pkg: shared types, constants and elaboration-time table builders
// for the sRGB to CIE xyY core. Depends on nothing.
package sxy_pkg;

    // quotient bits of each chromaticity divider (covers 0..65535 plus rounding)
    localparam int QBITS      = 17;
    localparam int CHROMA_MAX = 65535;
    localparam int BRIGHT_MAX = 255;

    // one finished result
    typedef struct packed {
        logic [7:0]  brightness;
        logic [15:0] chroma_x;
        logic [15:0] chroma_y;
        logic        is_black;
    } t_result;

    // queue status between two modules
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // sRGB to XYZ matrix, in units of 1/10000, row by row
    localparam int unsigned MAT_K [9] = '{
        4124, 3576, 1805,
        2126, 7152,  722,
         193, 1192, 9505
    };

    // matrix coefficient rounded to f fraction bits
    function automatic logic [63:0] coef_q(input int idx, input int f);
        logic [63:0] k;
        k = 64'(MAT_K[idx]);
        return ((k << f) + 64'd5000) / 64'd10000;
    endfunction

    // Q0.31 multiply with rounding
    function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // r to the fifth power in Q0.31
    function automatic logic [63:0] q31_pow5(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = q31_mul(r, r);
        r4 = q31_mul(r2, r2);
        return q31_mul(r4, r);
    endfunction

    // sRGB decode table entry for code c at f fraction bits
    function automatic logic [63:0] rom_entry(input int c, input int f);
        logic [63:0] n;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        if (c <= 10) begin
            n = 64'(c) * 64'd100 * (64'd1 << f) * 64'd2 + 64'd329460;
            return n / 64'd658920;
        end
        n  = 64'd1000 * 64'(c) + 64'd14025;
        t  = ((n << 32) + 64'd269025) / 64'd538050;
        s  = q31_mul(t, t);
        lo = 64'd0;
        hi = 64'd1 << 31;
        while (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            if (q31_pow5(mid) <= s) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        p = q31_mul(s, lo);
        return (p + (64'd1 << (30 - f))) >> (31 - f);
    endfunction

endpackage

FILE: rtl/core/sxy_fifo.sv
// sxy_fifo: small register queue with push/full and pop/empty sides.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module sxy_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // store incoming entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

FILE: rtl/core/sxy_front.sv
// sxy_front: input stage; decodes each sRGB channel through the constant
// table and flags black. Depends on sxy_pkg.
module sxy_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    output logic                 o_full,
    input  sxy_pkg::t_qstat      i_qstat,
    output logic                 o_qpush,
    output logic [3*FRAC_BITS+3:0] o_qdata
);
    localparam int RW = FRAC_BITS + 1;

    logic [RW-1:0] rom_c [256];
    logic          r_v;
    logic [RW-1:0] r_lr;
    logic [RW-1:0] r_lg;
    logic [RW-1:0] r_lb;
    logic          r_black;
    logic          load;

    // constant decode table
    for (genvar g = 0; g < 256; g++) begin : g_rom
        localparam logic [RW-1:0] ROMV = RW'(sxy_pkg::rom_entry(g, FRAC_BITS));
        assign rom_c[g] = ROMV;
    end

    assign o_full  = r_v && i_qstat.full;
    assign load    = i_push && !o_full;
    assign o_qpush = r_v;
    assign o_qdata = {r_black, r_lr, r_lg, r_lb};

    // hold stage valid until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (load) begin
            r_v <= 1'b1;
        end else if (!i_qstat.full) begin
            r_v <= 1'b0;
        end
    end

    // capture decoded levels
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_lr    <= rom_c[i_red];
            r_lg    <= rom_c[i_green];
            r_lb    <= rom_c[i_blue];
            r_black <= (i_red == 8'd0) && (i_green == 8'd0) && (i_blue == 8'd0);
        end
    end

endmodule

FILE: rtl/core/sxy_back.sv
// sxy_back: matrix, brightness and pipelined chromaticity dividers.
// Depends on sxy_pkg; pops the middle queue and pushes the result queue.
module sxy_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sxy_pkg::t_qstat        i_mid,
    input  logic [3*FRAC_BITS+3:0] i_mdata,
    output logic                   o_mpop,
    input  sxy_pkg::t_qstat        i_out,
    output logic                   o_opush,
    output sxy_pkg::t_result       o_odata
);
    localparam int RW = FRAC_BITS + 1;
    localparam int PW = 2 * RW;
    localparam int SW = 2 * FRAC_BITS + 3;
    localparam int BW = SW + 9;
    localparam int DW = SW + 1;
    localparam int NW = SW + sxy_pkg::QBITS + 1;
    localparam int QB = sxy_pkg::QBITS;

    logic          en;

    // stage A: decoded levels
    logic          r_va;
    logic [RW-1:0] r_lin [3];
    logic          r_ba;
    // stage B: products
    logic          r_vb;
    logic [PW-1:0] r_p [9];
    logic          r_bb;
    // stage C: X, Y, Z
    logic          r_vc;
    logic [SW-1:0] r_xyz [3];
    logic          r_bc;
    // stage D: X, Y, S, brightness
    logic          r_vd;
    logic [SW-1:0] r_xd;
    logic [SW-1:0] r_yd;
    logic [SW-1:0] r_sd;
    logic [7:0]    r_brd;
    logic          r_bd;
    // stage E: dividends and divisor
    logic          r_ve;
    logic [NW-1:0] r_nx;
    logic [NW-1:0] r_ny;
    logic [DW-1:0] r_d2;
    logic [7:0]    r_bre;
    logic          r_be;
    // divider stages
    logic          r_vq  [QB];
    logic [NW-1:0] r_rx  [QB];
    logic [NW-1:0] r_ry  [QB];
    logic [DW-1:0] r_dq  [QB];
    logic [QB-1:0] r_qx  [QB];
    logic [QB-1:0] r_qy  [QB];
    logic [7:0]    r_brq [QB];
    logic          r_bq  [QB];

    logic [BW-1:0] ysc;
    logic [BW-1:0] br_full;
    logic [NW-1:0] xd_w;
    logic [NW-1:0] yd_w;

    // advance the whole pipe unless the last result cannot leave
    assign en       = !r_vq[QB-1] || !i_out.full;
    assign o_mpop   = en;
    assign o_opush  = r_vq[QB-1];

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            for (int k = 0; k < QB; k++) begin
                r_vq[k] <= 1'b0;
            end
        end else if (en) begin
            r_va    <= !i_mid.empty;
            r_vb    <= r_va;
            r_vc    <= r_vb;
            r_vd    <= r_vc;
            r_ve    <= r_vd;
            r_vq[0] <= r_ve;
            for (int k = 1; k < QB; k++) begin
                r_vq[k] <= r_vq[k-1];
            end
        end
    end

    // take levels from the queue
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ba     <= i_mdata[3*RW];
            r_lin[0] <= i_mdata[3*RW-1:2*RW];
            r_lin[1] <= i_mdata[2*RW-1:RW];
            r_lin[2] <= i_mdata[RW-1:0];
        end
    end

    // nine coefficient products
    for (genvar g = 0; g < 9; g++) begin : g_mul
        localparam logic [RW-1:0] COEF = RW'(sxy_pkg::coef_q(g, FRAC_BITS));
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p[g] <= PW'(r_lin[g % 3]) * PW'(COEF);
            end
        end
    end

    // row sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bb <= r_ba;
            r_bc <= r_bb;
            for (int j = 0; j < 3; j++) begin
                r_xyz[j] <= SW'(r_p[3*j]) + SW'(r_p[3*j+1]) + SW'(r_p[3*j+2]);
            end
        end
    end

    // brightness: round Y * 255, saturate
    assign ysc     = {BW'(r_xyz[1]) << 8} - BW'(r_xyz[1])
                   + (BW'(1) << (2 * FRAC_BITS - 1));
    assign br_full = ysc >> (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xd  <= r_xyz[0];
            r_yd  <= r_xyz[1];
            r_sd  <= r_xyz[0] + r_xyz[1] + r_xyz[2];
            r_bd  <= r_bc;
            r_brd <= (br_full > BW'(sxy_pkg::BRIGHT_MAX)) ? 8'(sxy_pkg::BRIGHT_MAX)
                                                          : br_full[7:0];
        end
    end

    // dividends 2*65535*a + S by shift and subtract
    assign xd_w = (NW'(r_xd) << QB) - (NW'(r_xd) << 1) + NW'(r_sd);
    assign yd_w = (NW'(r_yd) << QB) - (NW'(r_yd) << 1) + NW'(r_sd);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx  <= xd_w;
            r_ny  <= yd_w;
            r_d2  <= {r_sd, 1'b0};
            r_bre <= r_brd;
            r_be  <= r_bd;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int BI = QB - 1 - k;
        logic [NW-1:0] in_rx;
        logic [NW-1:0] in_ry;
        logic [DW-1:0] in_d;
        logic [QB-1:0] in_qx;
        logic [QB-1:0] in_qy;
        logic [7:0]    in_br;
        logic          in_b;
        logic [NW-1:0] dsh;
        logic          gx;
        logic          gy;
        if (k == 0) begin : g_first
            assign in_rx = r_nx;
            assign in_ry = r_ny;
            assign in_d  = r_d2;
            assign in_qx = '0;
            assign in_qy = '0;
            assign in_br = r_bre;
            assign in_b  = r_be;
        end else begin : g_next
            assign in_rx = r_rx[k-1];
            assign in_ry = r_ry[k-1];
            assign in_d  = r_dq[k-1];
            assign in_qx = r_qx[k-1];
            assign in_qy = r_qy[k-1];
            assign in_br = r_brq[k-1];
            assign in_b  = r_bq[k-1];
        end
        assign dsh = NW'(in_d) << BI;
        assign gx  = (in_rx >= dsh);
        assign gy  = (in_ry >= dsh);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rx[k]  <= gx ? (in_rx - dsh) : in_rx;
                r_ry[k]  <= gy ? (in_ry - dsh) : in_ry;
                r_qx[k]  <= in_qx | (QB'(gx) << BI);
                r_qy[k]  <= in_qy | (QB'(gy) << BI);
                r_dq[k]  <= in_d;
                r_brq[k] <= in_br;
                r_bq[k]  <= in_b;
            end
        end
    end

    // clamp, force black to zero chromaticity
    always_comb begin
        o_odata.brightness = r_brq[QB-1];
        o_odata.is_black   = r_bq[QB-1];
        if (r_bq[QB-1]) begin
            o_odata.chroma_x = '0;
            o_odata.chroma_y = '0;
        end else begin
            o_odata.chroma_x = r_qx[QB-1][QB-1] ? 16'(sxy_pkg::CHROMA_MAX)
                                                : r_qx[QB-1][15:0];
            o_odata.chroma_y = r_qy[QB-1][QB-1] ? 16'(sxy_pkg::CHROMA_MAX)
                                                : r_qy[QB-1][15:0];
        end
    end

endmodule

FILE: rtl/core/srgb_to_cie_xy_brightness_core.sv
// srgb_to_cie_xy_brightness_core: top level, front stage, middle queue,
// back pipeline and result queue. Depends on sxy_pkg and the sxy_ modules.
//
//  channel   direction  handshake          payload
//  input     in         push / full        i_red, i_green, i_blue
//  result    out        empty / pop        o_brightness, o_chroma_x,
//                                          o_chroma_y, o_is_black
//
// One item is accepted per cycle while full is low; its result passes the
// front register, middle queue, five matrix/sum stages, the 17-stage
// chromaticity divider and the result queue.
// Reset is synchronous, active low, and empties both queues and the pipe.
// When the result queue fills, the back pipe holds, then the middle queue,
// then full rises at the input.
module srgb_to_cie_xy_brightness_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_brightness,
    output logic [15:0] o_chroma_x,
    output logic [15:0] o_chroma_y,
    output logic        o_is_black
);
    localparam int MW = 3 * FRAC_BITS + 4;
    localparam int OW = $bits(sxy_pkg::t_result);

    sxy_pkg::t_qstat  mid_st;
    sxy_pkg::t_qstat  out_st;
    sxy_pkg::t_result res_in;
    sxy_pkg::t_result res_out;
    logic             mid_push;
    logic [MW-1:0]    mid_din;
    logic [MW-1:0]    mid_dout;
    logic             mid_pop;
    logic             out_push;

    // accept and decode
    sxy_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_full  (full),
        .i_qstat (mid_st),
        .o_qpush (mid_push),
        .o_qdata (mid_din)
    );

    // decouple front and back
    sxy_fifo #(.W(MW), .DEPTH(2)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_din),
        .i_pop   (mid_pop),
        .o_data  (mid_dout),
        .o_full  (mid_st.full),
        .o_empty (mid_st.empty)
    );

    // matrix and dividers
    sxy_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mid   (mid_st),
        .i_mdata (mid_dout),
        .o_mpop  (mid_pop),
        .i_out   (out_st),
        .o_opush (out_push),
        .o_odata (res_in)
    );

    // result queue
    sxy_fifo #(.W(OW), .DEPTH(2)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_full  (out_st.full),
        .o_empty (out_st.empty)
    );

    assign empty        = out_st.empty;
    assign o_brightness = res_out.brightness;
    assign o_chroma_x   = res_out.chroma_x;
    assign o_chroma_y   = res_out.chroma_y;
    assign o_is_black   = res_out.is_black;

endmodule

FILE: rtl/core/sxy_checker.sv
// sxy_checker: port-level assertions for the core, attached by bind.
// Depends on srgb_to_cie_xy_brightness_core port names.
module sxy_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_brightness,
    input logic [15:0] o_chroma_x,
    input logic [15:0] o_chroma_y,
    input logic        o_is_black
);
    // reset drains the result side
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset opens the input side
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full asserted after reset");

    // a waiting result's chromaticity holds until transferred
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_chroma_x) && $stable(o_chroma_y)))
        else $error("waiting result changed");

    // black gives zero chromaticity and brightness
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_black) |->
            (o_chroma_x == 16'd0 && o_chroma_y == 16'd0 && o_brightness == 8'd0))
        else $error("black result with nonzero fields");

endmodule

bind srgb_to_cie_xy_brightness_core sxy_checker u_sxy_checker (.*);

FILE: test/srgb_to_cie_xy_brightness_core_test.sv
// Self-checking testbench for srgb_to_cie_xy_brightness_core: drives pixels
// through the push/full queue port and checks brightness and chromaticity
// at the empty/pop port. Depends on sxy_pkg and the core RTL.
`timescale 1ns / 1ps

module srgb_to_cie_xy_brightness_core_test;

    localparam int FRAC      = 16;
    localparam int IDLE_STOP = 20000;
    localparam int TAIL_WAIT = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic        empty;
    logic        pop;
    logic [7:0]  o_brightness;
    logic [15:0] o_chroma_x;
    logic [15:0] o_chroma_y;
    logic        o_is_black;

    logic [63:0]      lin_level [256];
    logic [63:0]      xyz_coef [9];
    sxy_pkg::t_result pending_colors [$];
    int               errors;
    int               receiver_hold;
    bit               receiver_steady;
    int               idle_cycles;

    srgb_to_cie_xy_brightness_core #(.FRAC_BITS(FRAC)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .empty(empty), .pop(pop), .o_brightness(o_brightness),
        .o_chroma_x(o_chroma_x), .o_chroma_y(o_chroma_y), .o_is_black(o_is_black)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Q0.31 product with rounding
    function automatic logic [63:0] fix31_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // sRGB code to linear light with FRAC fraction bits
    function automatic logic [63:0] decode_level(input int code);
        logic [63:0] t;
        logic [63:0] sq;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] r2;
        logic [63:0] pw;
        if (code <= 10)
            return (64'(code) * 64'd200 * (64'd1 << FRAC) + 64'd329460) / 64'd658920;
        t  = (((64'd1000 * 64'(code) + 64'd14025) << 32) + 64'd269025) / 64'd538050;
        sq = fix31_mul(t, t);
        lo = 64'd0;
        hi = 64'd1 << 31;
        // fifth root of t^2 by bisection
        while (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            r2  = fix31_mul(mid, mid);
            pw  = fix31_mul(fix31_mul(r2, r2), mid);
            if (pw <= sq) lo = mid;
            else hi = mid - 64'd1;
        end
        pw = fix31_mul(sq, lo);
        return (pw + (64'd1 << (30 - FRAC))) >> (31 - FRAC);
    endfunction

    // round_half_up(part * 65535 / total), clamped
    function automatic logic [15:0] chroma_code(input logic [63:0] part,
                                                input logic [63:0] total);
        logic [127:0] num;
        logic [127:0] q;
        num = 128'(part) * 128'd131070 + 128'(total);
        q   = num / (128'(total) * 128'd2);
        return (q > 128'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic sxy_pkg::t_result predict_color(input logic [7:0] r,
                                                       input logic [7:0] g,
                                                       input logic [7:0] b);
        sxy_pkg::t_result res;
        logic [63:0]      lx;
        logic [63:0]      ly;
        logic [63:0]      lz;
        logic [63:0]      sum;
        logic [63:0]      br;
        lx  = lin_level[r] * xyz_coef[0] + lin_level[g] * xyz_coef[1]
            + lin_level[b] * xyz_coef[2];
        ly  = lin_level[r] * xyz_coef[3] + lin_level[g] * xyz_coef[4]
            + lin_level[b] * xyz_coef[5];
        lz  = lin_level[r] * xyz_coef[6] + lin_level[g] * xyz_coef[7]
            + lin_level[b] * xyz_coef[8];
        sum = lx + ly + lz;
        br  = (ly * 64'd255 + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
        res.brightness = (br > 64'd255) ? 8'd255 : br[7:0];
        res.is_black   = (sum == 64'd0);
        res.chroma_x   = res.is_black ? 16'd0 : chroma_code(lx, sum);
        res.chroma_y   = res.is_black ? 16'd0 : chroma_code(ly, sum);
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // bias toward the ends and the linear segment of the curve
    function automatic logic [7:0] pick_level();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12) return 8'd0;
        if (roll < 22) return 8'd255;
        if (roll < 32) return 8'($urandom_range(12));
        return 8'($urandom_range(255));
    endfunction

    // offer one pixel, hold until the transfer, then drop push for the given gap
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input int gap);
        push    <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (full);
        pending_colors.push_back(predict_color(r, g, b));
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        int c;
        send_pixel(8'd0, 8'd0, 8'd0, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd255, 8'd0, 8'd0, 1);
        send_pixel(8'd0, 8'd255, 8'd0, 0);
        send_pixel(8'd0, 8'd0, 8'd255, 2);
        send_pixel(8'd1, 8'd0, 8'd0, 0);
        send_pixel(8'd0, 8'd0, 8'd1, 0);
        // both sides of the linear/power boundary of the decode curve
        for (c = 9; c <= 12; c++) send_pixel(8'(c), 8'(c), 8'(c), 0);
        send_pixel(8'd170, 8'd85, 8'd170, 0);
        send_pixel(8'd85, 8'd170, 8'd85, 3);
        send_pixel(8'd255, 8'd255, 8'd0, 0);
        send_pixel(8'd0, 8'd255, 8'd255, 0);
        send_pixel(8'd255, 8'd0, 8'd255, 0);
        send_pixel(8'd254, 8'd254, 8'd254, 0);
        send_pixel(8'd0, 8'd0, 8'd0, 0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            receiver_steady = (n >= count / 2) && (n < count / 2 + 60);
            send_pixel(pick_level(), pick_level(), pick_level(),
                       receiver_steady ? 0 : pick_gap());
        end
        receiver_steady = 1'b0;
        wait_drained();
    endtask

    // receiver holds off long enough that the block backs up and raises full
    task automatic test_backpressure();
        int n;
        receiver_hold = 250;
        for (n = 0; n < 90; n++) send_pixel(pick_level(), pick_level(), pick_level(), 0);
        wait_drained();
    endtask

    // receiver: random pop gaps, a long hold on request
    initial begin
        int gap_left;
        gap_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (receiver_hold > 0) begin
                pop <= 1'b0;
                repeat (receiver_hold) @(posedge i_clk);
                receiver_hold = 0;
            end else if (gap_left > 0) begin
                pop <= 1'b0;
                gap_left--;
            end else begin
                pop <= 1'b1;
                if (!receiver_steady) gap_left = pick_gap();
            end
        end
    end

    // check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        sxy_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected result bright=%0d x=%0d y=%0d black=%0b", $time,
                         o_brightness, o_chroma_x, o_chroma_y, o_is_black);
                errors++;
            end else begin
                want = pending_colors.pop_front();
                if (o_brightness !== want.brightness) begin
                    $display("%0t: brightness expected %0d actual %0d", $time,
                             want.brightness, o_brightness);
                    errors++;
                end
                if (o_chroma_x !== want.chroma_x) begin
                    $display("%0t: chroma_x expected %0d actual %0d", $time,
                             want.chroma_x, o_chroma_x);
                    errors++;
                end
                if (o_chroma_y !== want.chroma_y) begin
                    $display("%0t: chroma_y expected %0d actual %0d", $time,
                             want.chroma_y, o_chroma_y);
                    errors++;
                end
                if (o_is_black !== want.is_black) begin
                    $display("%0t: is_black expected %0b actual %0b", $time,
                             want.is_black, o_is_black);
                    errors++;
                end
            end
        end
    end

    // watchdog: abort when work is outstanding but nothing transfers
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n
                || (!push && pending_colors.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_STOP) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int c;
        errors          = 0;
        receiver_hold   = 0;
        receiver_steady = 1'b0;
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_red   <= 8'd0;
        i_green <= 8'd0;
        i_blue  <= 8'd0;
        for (c = 0; c < 256; c++) lin_level[c] = decode_level(c);
        for (c = 0; c < 9; c++)
            xyz_coef[c] = ((64'(sxy_pkg::MAT_K[c]) << FRAC) + 64'd5000) / 64'd10000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random(600);

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (errors == 0 && pending_colors.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sxy_pkg.sv
rtl/core/sxy_fifo.sv
rtl/core/sxy_front.sv
rtl/core/sxy_back.sv
rtl/core/srgb_to_cie_xy_brightness_core.sv
rtl/core/sxy_checker.sv
test/srgb_to_cie_xy_brightness_core_test.sv
